// ===== design/twg_pkg.sv =====
// Shared types and constants for the tearing-effect write gate.
`timescale 1ns / 1ps
`default_nettype none
package twg_pkg;

  // Input operation codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_EDGE   = 3'd1,
    OP_RENDER = 3'd2,
    OP_STRIP  = 3'd3,
    OP_REPORT = 3'd4
  } op_t;

  // Strip release reasons
  localparam logic [1:0] RSN_UNGATED = 2'd0;
  localparam logic [1:0] RSN_FRESH   = 2'd1;
  localparam logic [1:0] RSN_EDGE    = 2'd2;
  localparam logic [1:0] RSN_TIMEOUT = 2'd3;

  // Result kinds
  localparam logic KIND_STRIP  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_GATE_ENABLE = 2'd0;
  localparam logic [1:0] REG_FRESH_WIN   = 2'd1;
  localparam logic [1:0] REG_WAIT_TMO    = 2'd2;
  localparam logic [1:0] REG_GIVEUP      = 2'd3;

  // Configuration reset values
  localparam logic [15:0] FRESH_WIN_RST = 16'd2000;
  localparam logic [19:0] WAIT_TMO_RST  = 20'd25000;
  localparam logic [7:0]  GIVEUP_RST    = 8'd8;

  localparam int unsigned CFG_DATA_W = 20;

  // One result on its way through the divide stages
  typedef struct packed {
    logic        kind;
    logic [1:0]  reason;
    logic        live;
    logic [15:0] waits;
    logic [15:0] timeouts;
    logic        sum_ok;
    logic [31:0] sum;
  } twg_res_t;

  // Finished result as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [1:0]  reason;
    logic        live;
    logic [15:0] waits;
    logic [15:0] timeouts;
    logic [31:0] period;
  } twg_out_t;

endpackage
`default_nettype wire

// ===== design/twg_core.sv =====
// Input register, gate state and configuration registers of the write gate.
`timescale 1ns / 1ps
`default_nettype none
module twg_core #(
  parameter int unsigned PROBE_EDGES = 120
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               in_valid,
  input  wire logic [2:0]                         in_op,
  input  wire logic [31:0]                        in_now,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_addr,
  input  wire logic [twg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                    res_valid,
  output twg_pkg::twg_res_t                       res
);
  import twg_pkg::*;

  localparam logic [6:0] PROBE_N = 7'(PROBE_EDGES);

  // Configuration registers
  logic        gate_en_r;
  logic [15:0] fresh_r;
  logic [19:0] tmo_r;
  logic [7:0]  giveup_r;

  // Input register
  logic        s0_valid_r;
  logic [2:0]  op_r;
  logic [31:0] now_r;

  // Gate state
  logic        nlo_r, nlo_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [6:0]  filled_r, filled_nxt;
  logic        armed_r, armed_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] wstart_r, wstart_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic [15:0] waits_r, waits_nxt;
  logic [15:0] tmos_r, tmos_nxt;

  // Result register
  logic        s1_valid_r;
  twg_res_t    s1_r;
  logic        emit;
  twg_res_t    res_nxt;

  logic        step;
  logic [31:0] age_wait;
  logic [31:0] age_edge;
  logic        timed_out;
  logic        fresh_edge;
  logic [7:0]  miss_inc;

  assign step       = adv && s0_valid_r;
  assign age_wait   = now_r - wstart_r;
  assign age_edge   = now_r - last_r;
  assign timed_out  = pend_r && (age_wait >= {12'd0, tmo_r});
  assign fresh_edge = seen_r && (age_edge < {16'd0, fresh_r});
  assign miss_inc   = (miss_r < giveup_r) ? miss_r + 8'd1 : miss_r;

  // Next state and result for the item in the input register
  always_comb begin
    nlo_nxt    = nlo_r;
    seen_nxt   = seen_r;
    last_nxt   = last_r;
    sum_nxt    = sum_r;
    filled_nxt = filled_r;
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    wstart_nxt = wstart_r;
    miss_nxt   = miss_r;
    waits_nxt  = waits_r;
    tmos_nxt   = tmos_r;
    emit       = 1'b0;
    res_nxt    = '0;
    if (step) begin
      unique case (op_r)
        OP_TICK: begin
          if (timed_out) begin
            pend_nxt = 1'b0;
            tmos_nxt = (tmos_r != 16'hFFFF) ? tmos_r + 16'd1 : tmos_r;
            miss_nxt = miss_inc;
            if (miss_inc >= giveup_r) nlo_nxt = 1'b0;
            emit = 1'b1;
            res_nxt.reason = RSN_TIMEOUT;
          end
        end
        OP_EDGE: begin
          if (seen_r && (filled_r < PROBE_N)) begin
            sum_nxt    = sum_r + age_edge;
            filled_nxt = filled_r + 7'd1;
          end
          last_nxt = now_r;
          seen_nxt = 1'b1;
          if (timed_out) begin
            pend_nxt = 1'b0;
            tmos_nxt = (tmos_r != 16'hFFFF) ? tmos_r + 16'd1 : tmos_r;
            miss_nxt = miss_inc;
            if (miss_inc >= giveup_r) nlo_nxt = 1'b0;
            emit = 1'b1;
            res_nxt.reason = RSN_TIMEOUT;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
            miss_nxt = 8'd0;
            emit = 1'b1;
            res_nxt.reason = RSN_EDGE;
          end
        end
        OP_RENDER: begin
          armed_nxt = 1'b1;
        end
        OP_STRIP: begin
          if (!pend_r) begin
            armed_nxt = 1'b0;
            if (!armed_r || !(gate_en_r && nlo_r)) begin
              emit = 1'b1;
              res_nxt.reason = RSN_UNGATED;
            end else begin
              waits_nxt = (waits_r != 16'hFFFF) ? waits_r + 16'd1 : waits_r;
              if (fresh_edge) begin
                miss_nxt = 8'd0;
                emit = 1'b1;
                res_nxt.reason = RSN_FRESH;
              end else begin
                pend_nxt   = 1'b1;
                wstart_nxt = now_r;
              end
            end
          end
        end
        OP_REPORT: begin
          emit = 1'b1;
          res_nxt.kind     = KIND_REPORT;
          res_nxt.waits    = waits_r;
          res_nxt.timeouts = tmos_r;
          res_nxt.sum_ok   = (filled_r >= PROBE_N);
          res_nxt.sum      = sum_r;
          waits_nxt = 16'd0;
          tmos_nxt  = 16'd0;
        end
        default: begin
        end
      endcase
    end
    // Gating status as it stands after the item
    res_nxt.live = gate_en_r && nlo_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_en_r <= 1'b0;
      fresh_r   <= FRESH_WIN_RST;
      tmo_r     <= WAIT_TMO_RST;
      giveup_r  <= GIVEUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GATE_ENABLE: gate_en_r <= cfg_wdata[0];
        REG_FRESH_WIN:   fresh_r   <= cfg_wdata[15:0];
        REG_WAIT_TMO:    tmo_r     <= cfg_wdata[19:0];
        REG_GIVEUP:      giveup_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      nlo_r      <= 1'b1;
      seen_r     <= 1'b0;
      last_r     <= 32'd0;
      sum_r      <= 32'd0;
      filled_r   <= 7'd0;
      armed_r    <= 1'b0;
      pend_r     <= 1'b0;
      wstart_r   <= 32'd0;
      miss_r     <= 8'd0;
      waits_r    <= 16'd0;
      tmos_r     <= 16'd0;
    end else begin
      nlo_r    <= nlo_nxt;
      seen_r   <= seen_nxt;
      last_r   <= last_nxt;
      sum_r    <= sum_nxt;
      filled_r <= filled_nxt;
      armed_r  <= armed_nxt;
      pend_r   <= pend_nxt;
      wstart_r <= wstart_nxt;
      miss_r   <= miss_nxt;
      waits_r  <= waits_nxt;
      tmos_r   <= tmos_nxt;
      if (adv) begin
        s0_valid_r <= in_valid;
        s1_valid_r <= emit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      op_r  <= in_op;
      now_r <= in_now;
      s1_r  <= res_nxt;
    end
  end

  assign res_valid = s1_valid_r;
  assign res       = s1_r;

endmodule
`default_nettype wire

// ===== design/twg_div.sv =====
// Two-stage constant divide of the probe sum, ending in the output register.
`timescale 1ns / 1ps
`default_nettype none
module twg_div #(
  parameter int unsigned PROBE_EDGES = 120
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               res_valid,
  input  wire twg_pkg::twg_res_t  res,
  output logic                    out_valid,
  output twg_pkg::twg_out_t       out
);
  import twg_pkg::*;

  // Reciprocal scaled so that it fits 32 bits; the estimate is low by at most one
  localparam int unsigned SH = 31 + $clog2(PROBE_EDGES);
  localparam logic [63:0] RECIP_W = (64'd1 << SH) / 64'(PROBE_EDGES);
  localparam logic [31:0] RECIP = RECIP_W[31:0];
  localparam logic [31:0] DIV_N = 32'(PROBE_EDGES);

  logic        s2_valid_r;
  twg_res_t    s2_r;
  logic [31:0] q0_r;
  logic [63:0] prod;

  logic        o_valid_r;
  twg_out_t    o_r;
  twg_out_t    o_nxt;
  logic [31:0] rem;
  logic [31:0] quot;

  // Multiply by the reciprocal
  assign prod = {32'd0, res.sum} * {32'd0, RECIP};

  // Remainder correction
  always_comb begin
    rem  = s2_r.sum - 32'(q0_r * DIV_N);
    quot = (rem >= DIV_N) ? q0_r + 32'd1 : q0_r;
    o_nxt.kind     = s2_r.kind;
    o_nxt.reason   = s2_r.reason;
    o_nxt.live     = s2_r.live;
    o_nxt.waits    = s2_r.waits;
    o_nxt.timeouts = s2_r.timeouts;
    o_nxt.period   = s2_r.sum_ok ? quot : 32'd0;
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= res_valid;
      o_valid_r  <= s2_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= res;
      q0_r <= 32'(prod >> SH);
      o_r  <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out       = o_r;

endmodule
`default_nettype wire

// ===== design/tearing_effect_write_gate.sv =====
// Top level of the tearing-effect write gate.
`timescale 1ns / 1ps
`default_nettype none
// Takes one transaction in every cycle while the output is not stalled. Its result, if
// any, is offered on the output after the gate state update into the result register,
// the reciprocal multiply and the remainder correction into the output register. The
// pipeline moves as one: in_tready is high
// whenever the output register is empty or being taken, so a stalled output holds the
// input side. Strip transactions carry the release reason; window reports carry the
// wait and timeout counts, which they clear, and the mean TE period over the first
// PROBE_EDGES edge intervals (0 until that many intervals are in). Configuration is
// written through cfg_we/cfg_addr/cfg_wdata and takes effect on the next cycle.
module tearing_effect_write_gate #(
  parameter int unsigned PROBE_EDGES = 120
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [31:0]                    in_tdata,  // now_us
  input  wire logic [2:0]                     in_tuser,  // op
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // reason[1:0], gating_live, window_waits[15:0], window_timeouts[15:0], period_us[31:0]
  output logic [71:0]                         out_tdata,
  output logic                                out_tuser, // kind
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_addr,
  input  wire logic [twg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import twg_pkg::*;

  logic     adv;
  logic     res_valid;
  twg_res_t res;
  twg_out_t out;

  // Whole pipeline advances when the output register can take a new value
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  twg_core #(.PROBE_EDGES(PROBE_EDGES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_now    (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  twg_div #(.PROBE_EDGES(PROBE_EDGES)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_tvalid),
    .out       (out)
  );

  // Output packing
  assign out_tuser = out.kind;
  assign out_tdata = {5'd0, out.period, out.timeouts, out.waits, out.live, out.reason};

endmodule
`default_nettype wire

// ===== design/twg_checker.sv =====
// Port-level checks for the tearing-effect write gate, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module twg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic        out_tuser
);

  // No result is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input side is free exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready disagrees with output state");

  // Strip results carry no window figures
  a_strip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[71:3] == 69'd0)
    else $error("strip result carries window figures");

  // Window reports carry no release reason
  a_report_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == 2'd0)
    else $error("window report carries a reason");

endmodule

bind tearing_effect_write_gate twg_checker u_twg_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the tearing-effect write gate.
`timescale 1ns / 1ps
module tb;
  import twg_pkg::*;

  localparam int unsigned PROBE_N = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  // Operation codes that the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // One input transaction, with an optional hand-written expectation.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic        typed;
    twg_out_t    want;
  } gate_item_t;

  // One row of the directed table: a register write or a transaction.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  addr;
    logic [19:0] wdata;
    gate_item_t  item;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // now_us
  logic [2:0]            in_tuser;   // op
  logic                  out_tvalid;
  logic                  out_tready;
  // reason[1:0], gating_live, window_waits[15:0], window_timeouts[15:0], period_us[31:0]
  logic [71:0]           out_tdata;
  logic                  out_tuser;  // kind
  logic                  cfg_we;
  logic [1:0]            cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gate_item_t stim_q[$];
  twg_out_t   pending_results[$];
  dir_row_t   dir_tab[$];
  gate_item_t on_bus;
  int         err_count = 0;
  bit         send_idle = 1'b1;
  bit         recv_idle = 1'b1;
  bit         hold_req = 1'b0;
  logic [31:0] now_clk;
  logic [31:0] next_te;

  // Predictor copy of the configuration and the gate state.
  logic        en_r;
  logic [15:0] fresh_r;
  logic [19:0] tmo_r;
  logic [7:0]  giveup_r;
  logic        not_off;
  logic        seen;
  logic [31:0] edge_t;
  logic [31:0] sum_acc;
  int unsigned probed;
  logic        armed;
  logic        waiting;
  logic [31:0] wait_t;
  logic [7:0]  streak;
  logic [15:0] n_waits;
  logic [15:0] n_tmos;

  tearing_effect_write_gate #(.PROBE_EDGES(PROBE_N)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Bring the predictor to its state after reset.
  function automatic void reset_gate_state();
    en_r     = 1'b0;
    fresh_r  = FRESH_WIN_RST;
    tmo_r    = WAIT_TMO_RST;
    giveup_r = GIVEUP_RST;
    not_off  = 1'b1;
    seen     = 1'b0;
    edge_t   = '0;
    sum_acc  = '0;
    probed   = 0;
    armed    = 1'b0;
    waiting  = 1'b0;
    wait_t   = '0;
    streak   = '0;
    n_waits  = '0;
    n_tmos   = '0;
  endfunction

  // A wait that ran out: count it and latch gating off after too many in a row.
  function automatic void record_timeout();
    waiting = 1'b0;
    if (n_tmos != 16'hFFFF) n_tmos++;
    if (streak < giveup_r) streak++;
    if (streak >= giveup_r) not_off = 1'b0;
  endfunction

  function automatic twg_out_t strip_release(logic [1:0] why);
    twg_out_t r;
    r = '0;
    r.kind   = KIND_STRIP;
    r.reason = why;
    r.live   = en_r & not_off;
    return r;
  endfunction

  // Advance the gate by one transaction; returns 1 when it releases a result.
  function automatic bit predict_gate(logic [2:0] op, logic [31:0] now, output twg_out_t res);
    logic [31:0] wait_age;
    logic [31:0] edge_age;
    res = '0;
    wait_age = now - wait_t;
    edge_age = now - edge_t;
    case (op)
      OP_TICK: begin
        if (waiting && wait_age >= {12'd0, tmo_r}) begin
          record_timeout();
          res = strip_release(RSN_TIMEOUT);
          return 1'b1;
        end
      end
      OP_EDGE: begin
        if (seen && probed < PROBE_N) begin
          sum_acc = sum_acc + edge_age;
          probed++;
        end
        edge_t = now;
        seen   = 1'b1;
        if (waiting) begin
          if (wait_age >= {12'd0, tmo_r}) begin
            record_timeout();
            res = strip_release(RSN_TIMEOUT);
          end else begin
            waiting = 1'b0;
            streak  = '0;
            res = strip_release(RSN_EDGE);
          end
          return 1'b1;
        end
      end
      OP_RENDER: armed = 1'b1;
      OP_STRIP: begin
        if (!waiting) begin
          if (!armed || !(en_r && not_off)) begin
            armed = 1'b0;
            res = strip_release(RSN_UNGATED);
            return 1'b1;
          end
          armed = 1'b0;
          if (n_waits != 16'hFFFF) n_waits++;
          if (seen && edge_age < {16'd0, fresh_r}) begin
            streak = '0;
            res = strip_release(RSN_FRESH);
            return 1'b1;
          end
          waiting = 1'b1;
          wait_t  = now;
        end
      end
      OP_REPORT: begin
        res.kind     = KIND_REPORT;
        res.live     = en_r & not_off;
        res.waits    = n_waits;
        res.timeouts = n_tmos;
        res.period   = (probed >= PROBE_N) ? sum_acc / PROBE_N : 32'd0;
        n_waits = '0;
        n_tmos  = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Compare one result transaction with the oldest expectation.
  function automatic void check_result(logic kind, logic [71:0] data);
    twg_out_t want;
    if (pending_results.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result, expected none, got kind %0d data %h",
               $time, kind, data);
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", 32'(want.kind), 32'(kind));
    check_field("reason", 32'(want.reason), 32'(data[1:0]));
    check_field("gating_live", 32'(want.live), 32'(data[2]));
    check_field("window_waits", 32'(want.waits), 32'(data[18:3]));
    check_field("window_timeouts", 32'(want.timeouts), 32'(data[34:19]));
    check_field("period_us", want.period, data[66:35]);
  endfunction

  function automatic void push_item(logic [2:0] op, logic [31:0] now);
    gate_item_t it;
    it = '0;
    it.op  = op;
    it.now = now;
    stim_q.push_back(it);
  endfunction

  function automatic void add_item(logic [2:0] op, logic [31:0] now);
    dir_row_t row;
    row = '0;
    row.item.op  = op;
    row.item.now = now;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_typed(logic [2:0] op, logic [31:0] now, logic kind,
                                    logic [1:0] why, logic live);
    dir_row_t row;
    row = '0;
    row.item.op          = op;
    row.item.now         = now;
    row.item.typed       = 1'b1;
    row.item.want.kind   = kind;
    row.item.want.reason = why;
    row.item.want.live   = live;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_cfg(logic [1:0] addr, logic [19:0] data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.wdata  = data;
    dir_tab.push_back(row);
  endfunction

  // Wait until nothing is queued, on the bus or outstanding, then let the pipeline empty.
  // The outer loop catches a last transaction that went onto the bus in the same step.
  task automatic wait_drained();
    do begin
      do @(posedge clk);
      while (stim_q.size() != 0 || in_tvalid || pending_results.size() != 0);
      repeat (8) @(posedge clk);
    end while (in_tvalid || pending_results.size() != 0);
  endtask

  // Registers are only written while the block is idle.
  task automatic write_reg(logic [1:0] addr, logic [19:0] data);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_GATE_ENABLE: en_r     = data[0];
      REG_FRESH_WIN:   fresh_r  = data[15:0];
      REG_WAIT_TMO:    tmo_r    = data[19:0];
      REG_GIVEUP:      giveup_r = data[7:0];
      default: ;
    endcase
  endtask

  // Jump to the next TE edge; about one edge in seven goes missing.
  function automatic void take_edge(int unsigned period);
    now_clk = next_te;
    if ($urandom_range(0, 6) != 0) push_item(OP_EDGE, now_clk);
    next_te = next_te + period - period / 16 + $urandom_range(0, period / 8);
  endfunction

  // Render cycles on a running panel clock, mixed with reports and noise.
  task automatic run_traffic(int n_items, int unsigned period, bit pause_mid, bit hold_mid);
    int          sent;
    int          steps;
    int unsigned step;
    logic [31:0] ahead;
    sent = 0;
    while (sent < n_items) begin
      if (hold_mid && sent >= n_items / 3) begin
        hold_req = ~hold_req;
        hold_mid = 1'b0;
      end
      if (pause_mid && sent >= n_items / 2) begin
        wait_drained();
        pause_mid = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: begin
          push_item(3'($urandom_range(0, 7)), $urandom());
          sent++;
        end
        1: begin
          push_item(OP_REPORT, now_clk);
          sent++;
        end
        default: begin
          // Sometimes start the frame just after an edge so the fresh path is taken.
          if ($urandom_range(0, 2) == 0) begin
            take_edge(period);
            now_clk += $urandom_range(0, 2500);
            sent++;
          end
          push_item(OP_RENDER, now_clk);
          now_clk += $urandom_range(0, 2500);
          push_item(OP_STRIP, now_clk);
          sent += 2;
          steps = $urandom_range(2, 8);
          for (int k = 0; k < steps; k++) begin
            step  = $urandom_range(1, period / 3);
            ahead = now_clk + step - next_te;
            if (!ahead[31]) begin
              take_edge(period);
            end else begin
              now_clk += step;
              push_item(($urandom_range(0, 9) == 0) ? OP_STRIP : OP_TICK, now_clk);
            end
            sent++;
          end
        end
      endcase
    end
  endtask

  // Input side: present queued transactions and predict each one as it is accepted.
  initial begin
    twg_out_t res;
    bit       fires;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    on_bus    = '0;
    forever begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        fires = predict_gate(on_bus.op, on_bus.now, res);
        if (on_bus.typed) pending_results.push_back(on_bus.want);
        else if (fires) pending_results.push_back(res);
      end
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && !(send_idle && $urandom_range(0, 99) < 30)) begin
          on_bus = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.op;
          in_tdata  <= on_bus.now;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left  = 0;
    hold_seen  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result(out_tuser, out_tdata);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(recv_idle && $urandom_range(0, 99) < 30);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    now_clk   = 32'd100000;
    next_te   = 32'd101000;
    reset_gate_state();

    // Gating is off after reset.
    add_typed(OP_REPORT, 32'd0, KIND_REPORT, RSN_UNGATED, 1'b0);
    add_typed(OP_STRIP, 32'd100, KIND_STRIP, RSN_UNGATED, 1'b0);
    add_item(OP_RENDER, 32'd200);
    add_typed(OP_STRIP, 32'd300, KIND_STRIP, RSN_UNGATED, 1'b0);
    add_item(OP_SPARE_LO, 32'hFFFF_FFFF);
    add_item(OP_SPARE_HI, 32'd0);
    add_cfg(REG_GATE_ENABLE, 20'd1);
    // Tick with no wait, then the first edge, which only sets the time.
    add_item(OP_TICK, 32'd400);
    add_item(OP_EDGE, 32'd1000);
    // Edge just young enough, then just too old.
    add_item(OP_RENDER, 32'd2000);
    add_typed(OP_STRIP, 32'd2999, KIND_STRIP, RSN_FRESH, 1'b1);
    add_item(OP_RENDER, 32'd3000);
    add_item(OP_STRIP, 32'd3000);
    // Strip while a wait is pending is dropped; the next edge ends the wait.
    add_item(OP_STRIP, 32'd3100);
    add_typed(OP_EDGE, 32'd4000, KIND_STRIP, RSN_EDGE, 1'b1);
    // Wait that runs out on a tick, one microsecond after the last quiet tick.
    add_item(OP_RENDER, 32'd10000);
    add_item(OP_STRIP, 32'd10000);
    add_item(OP_TICK, 32'd34999);
    add_typed(OP_TICK, 32'd35000, KIND_STRIP, RSN_TIMEOUT, 1'b1);
    add_typed(OP_STRIP, 32'd35100, KIND_STRIP, RSN_UNGATED, 1'b1);
    add_item(OP_REPORT, 32'd36000);
    // An edge that arrives after the timeout still times the wait out.
    add_item(OP_RENDER, 32'd40000);
    add_item(OP_STRIP, 32'd40000);
    add_typed(OP_EDGE, 32'd65000, KIND_STRIP, RSN_TIMEOUT, 1'b1);
    add_item(OP_REPORT, 32'd65001);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].addr, dir_tab[i].wdata);
      else stim_q.push_back(dir_tab[i].item);
    end

    // Nominal panel rate, with a long receiver hold-off and a full drain midway.
    write_reg(REG_GIVEUP, 20'd255);
    run_traffic(320, 16667, 1'b1, 1'b1);

    // Widest windows across the timestamp wrap, with no idling on either side.
    write_reg(REG_FRESH_WIN, 20'hFFFF);
    write_reg(REG_WAIT_TMO, 20'hFFFFF);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    now_clk = 32'hFFFF_0000;
    next_te = now_clk + 1000;
    run_traffic(260, 16667, 1'b0, 1'b0);

    // Gating switched off, no fresh window.
    write_reg(REG_GATE_ENABLE, 20'd0);
    write_reg(REG_FRESH_WIN, 20'd0);
    write_reg(REG_WAIT_TMO, 20'd20000);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    run_traffic(200, 8333, 1'b0, 1'b0);

    // Shortest non-zero timeout: most waits run out.
    write_reg(REG_GATE_ENABLE, 20'd1);
    write_reg(REG_WAIT_TMO, 20'd1);
    run_traffic(150, 20000, 1'b0, 1'b0);

    // Panel rate drawn at random, with a second hold-off.
    write_reg(REG_FRESH_WIN, 20'd5000);
    write_reg(REG_WAIT_TMO, 20'd30000);
    run_traffic(300, $urandom_range(5000, 40000), 1'b0, 1'b1);

    // Zero timeout and zero give-up count: the first timeout latches gating off.
    write_reg(REG_WAIT_TMO, 20'd0);
    write_reg(REG_GIVEUP, 20'd0);
    run_traffic(200, 16667, 1'b0, 1'b0);

    // Back to the reset window, timeout and give-up settings, with gating latched off for good.
    write_reg(REG_FRESH_WIN, 20'(FRESH_WIN_RST));
    write_reg(REG_WAIT_TMO, WAIT_TMO_RST);
    write_reg(REG_GIVEUP, 20'(GIVEUP_RST));
    run_traffic(200, 16667, 1'b0, 1'b0);

    wait_drained();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
